### sv/qvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants and types for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // default vector component width
  localparam int VEC_WIDTH_DEF = 16;
  // default fraction bits of the quaternion components
  localparam int QUAT_FRAC_DEF = 14;
  // quaternion components are always 16-bit signed
  localparam int QUAT_WIDTH = 16;
  // product of two quaternion components
  localparam int QPROD_WIDTH = 2 * QUAT_WIDTH;
  // rotation matrix entry: 35 bits, one more than the 34 bits that twice a difference of two products needs
  localparam int ROW_WIDTH = QPROD_WIDTH + 3;
  // number of pipeline stages
  localparam int NUM_STAGES = 5;

  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
  typedef logic signed [QPROD_WIDTH-1:0] qprod_t;
  typedef logic signed [ROW_WIDTH-1:0]   row_t;

endpackage
`default_nettype wire

### sv/quaternion_vector_rotate_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a signed vector by a Q2.14 quaternion as q * (0, v) * conj(q),
// with rounding half up and saturation of every component.
// ----------------------------------------------------------------------------
// Fully pipelined rotator: one transaction is accepted per cycle unless a
// stalled output has filled the pipeline. The quaternion is first expanded into a
// 3x3 rotation matrix (component products, then matrix entries), the matrix
// is multiplied by the vector with nine parallel multipliers, the three
// row sums are formed with the rounding constant, and the final stage
// shifts out 2*QUAT_FRAC_BITS fraction bits and saturates to VEC_WIDTH bits.
// The quaternion is not normalized, so results scale with |q|^2; clipped
// is set when any component saturated. A stalled output holds the pipeline
// only as far back as it is full, so bubbles are squeezed out under stall.

module quaternion_vector_rotate_top #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [VEC_WIDTH-1:0] in_vec_x,
  input  wire logic signed [VEC_WIDTH-1:0] in_vec_y,
  input  wire logic signed [VEC_WIDTH-1:0] in_vec_z,
  input  wire qvr_pkg::quat_t              in_quat_i,
  input  wire qvr_pkg::quat_t              in_quat_j,
  input  wire qvr_pkg::quat_t              in_quat_k,
  input  wire qvr_pkg::quat_t              in_quat_r,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [VEC_WIDTH-1:0]      out_rot_x,
  output logic signed [VEC_WIDTH-1:0]      out_rot_y,
  output logic signed [VEC_WIDTH-1:0]      out_rot_z,
  output logic                             out_clipped
);

  localparam int NS     = qvr_pkg::NUM_STAGES;
  localparam int ROW_W  = qvr_pkg::ROW_WIDTH;
  localparam int PW     = ROW_W + VEC_WIDTH;
  localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
  // row sum width: three products plus rounding, wide enough for the shift
  localparam int SW_A   = PW + 3;
  localparam int SW     = (SW_A > SHIFT + 2) ? SW_A : SHIFT + 2;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (SHIFT - 1);

  // stage valids and per-stage load enables
  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  // stage 1: quaternion component products
  qvr_pkg::qprod_t rr_r, ii_r, jj_r, kk_r, ij_r, ik_r, jk_r, ri_r, rj_r, rk_r;
  logic signed [VEC_WIDTH-1:0] vec1_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rr_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_r) * qvr_pkg::QPROD_WIDTH'(in_quat_r);
      ii_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_i) * qvr_pkg::QPROD_WIDTH'(in_quat_i);
      jj_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_j) * qvr_pkg::QPROD_WIDTH'(in_quat_j);
      kk_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_k) * qvr_pkg::QPROD_WIDTH'(in_quat_k);
      ij_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_i) * qvr_pkg::QPROD_WIDTH'(in_quat_j);
      ik_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_i) * qvr_pkg::QPROD_WIDTH'(in_quat_k);
      jk_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_j) * qvr_pkg::QPROD_WIDTH'(in_quat_k);
      ri_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_r) * qvr_pkg::QPROD_WIDTH'(in_quat_i);
      rj_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_r) * qvr_pkg::QPROD_WIDTH'(in_quat_j);
      rk_r      <= qvr_pkg::QPROD_WIDTH'(in_quat_r) * qvr_pkg::QPROD_WIDTH'(in_quat_k);
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
    end
  end

  // stage 2: rotation matrix entries
  qvr_pkg::row_t rr_e, ii_e, jj_e, kk_e, ij_e, ik_e, jk_e, ri_e, rj_e, rk_e;
  qvr_pkg::row_t mat_nxt [3][3];
  qvr_pkg::row_t mat_r   [3][3];
  logic signed [VEC_WIDTH-1:0] vec2_r [3];

  always_comb begin
    rr_e = ROW_W'(rr_r);
    ii_e = ROW_W'(ii_r);
    jj_e = ROW_W'(jj_r);
    kk_e = ROW_W'(kk_r);
    ij_e = ROW_W'(ij_r);
    ik_e = ROW_W'(ik_r);
    jk_e = ROW_W'(jk_r);
    ri_e = ROW_W'(ri_r);
    rj_e = ROW_W'(rj_r);
    rk_e = ROW_W'(rk_r);
    mat_nxt[0][0] = rr_e + ii_e - jj_e - kk_e;
    mat_nxt[0][1] = (ij_e - rk_e) <<< 1;
    mat_nxt[0][2] = (ik_e + rj_e) <<< 1;
    mat_nxt[1][0] = (ij_e + rk_e) <<< 1;
    mat_nxt[1][1] = rr_e - ii_e + jj_e - kk_e;
    mat_nxt[1][2] = (jk_e - ri_e) <<< 1;
    mat_nxt[2][0] = (ik_e - rj_e) <<< 1;
    mat_nxt[2][1] = (jk_e + ri_e) <<< 1;
    mat_nxt[2][2] = rr_e - ii_e - jj_e + kk_e;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mat_r  <= mat_nxt;
      vec2_r <= vec1_r;
    end
  end

  // stage 3: matrix times vector, nine parallel multipliers
  logic signed [PW-1:0] prod_r [3][3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PW'(mat_r[r][c]) * PW'(vec2_r[c]);
        end
      end
    end
  end

  // stage 4: row sums with the half-up rounding constant
  logic signed [SW-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2]) + RND;
      end
    end
  end

  // stage 5: drop fraction bits and saturate
  logic signed [SW-1:0]        shf    [3];
  logic signed [VEC_WIDTH-1:0] rot_nxt [3];
  logic [2:0]                  sat;
  logic signed [VEC_WIDTH-1:0] rot_r  [3];
  logic                        clip_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shf[r] = acc_r[r] >>> SHIFT;
      sat[r] = !((&shf[r][SW-1:VEC_WIDTH-1]) || !(|shf[r][SW-1:VEC_WIDTH-1]));
      if (!sat[r]) begin
        rot_nxt[r] = shf[r][VEC_WIDTH-1:0];
      end else if (shf[r][SW-1]) begin
        rot_nxt[r] = {1'b1, {(VEC_WIDTH-1){1'b0}}};
      end else begin
        rot_nxt[r] = {1'b0, {(VEC_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rot_r  <= rot_nxt;
      clip_r <= |sat;
    end
  end

  assign out_valid   = vld_r[NS-1];
  assign out_rot_x   = rot_r[0];
  assign out_rot_y   = rot_r[1];
  assign out_rot_z   = rot_r[2];
  assign out_clipped = clip_r;

endmodule
`default_nettype wire
